// ===== design/atcc_pkg.sv =====
// shared constants, field widths and tag lookup for the averaged telemetry block
// no dependencies
`timescale 1ns / 1ps

package atcc_pkg;

    // field and state widths
    localparam int SAMPLE_W = 8;
    localparam int SUM_W    = 14;
    localparam int CNT_W    = 6;
    localparam int CH_W     = 2;
    localparam int ROUND_W  = 4;
    localparam int AVG_W    = 8;
    localparam int BYTE_W   = 8;
    localparam int IDX_W    = 2;
    localparam int CFG_W    = 8;

    localparam int SAMPLES_PER_AVERAGE_DEF = 40;

    // register reset values
    localparam logic [7:0]         HIGH_THRESHOLD_RST = 8'd230;
    localparam logic [7:0]         LOW_THRESHOLD_RST  = 8'd161;
    localparam logic [ROUND_W-1:0] ROUNDS_RST         = 4'd5;

    // register indexes
    localparam logic [1:0] REG_HIGH_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_LOW_THRESHOLD  = 2'd1;
    localparam logic [1:0] REG_ROUNDS         = 2'd2;

    // channel codes
    localparam logic [CH_W-1:0] CH_TEMP    = 2'd0;
    localparam logic [CH_W-1:0] CH_VOLTAGE = 2'd1;
    localparam logic [CH_W-1:0] CH_CURRENT = 2'd2;

    // byte positions within one group
    localparam logic [IDX_W-1:0] POS_TAG0 = 2'd0;
    localparam logic [IDX_W-1:0] POS_TAG1 = 2'd1;
    localparam logic [IDX_W-1:0] POS_AVG  = 2'd2;

    // tag letters
    localparam logic [BYTE_W-1:0] CHR_P = 8'h70;
    localparam logic [BYTE_W-1:0] CHR_M = 8'h6d;
    localparam logic [BYTE_W-1:0] CHR_S = 8'h73;
    localparam logic [BYTE_W-1:0] CHR_K = 8'h6b;
    localparam logic [BYTE_W-1:0] CHR_F = 8'h66;
    localparam logic [BYTE_W-1:0] CHR_H = 8'h68;

    // two-letter channel tag, second selects the second letter
    function automatic logic [BYTE_W-1:0] tag_char(input logic [CH_W-1:0] ch,
                                                   input logic second);
        logic [BYTE_W-1:0] c;
        case (ch)
            CH_TEMP:    c = second ? CHR_M : CHR_P;
            CH_VOLTAGE: c = second ? CHR_K : CHR_S;
            default:    c = second ? CHR_H : CHR_F;
        endcase
        return c;
    endfunction

endpackage

// ===== design/atcc_avg_div.sv =====
// group average: sum divided by the sample count via reciprocal multiply
// depends on atcc_pkg
`timescale 1ns / 1ps

module atcc_avg_div #(
    parameter int SAMPLES_PER_AVERAGE = atcc_pkg::SAMPLES_PER_AVERAGE_DEF
) (
    input  logic [atcc_pkg::SUM_W-1:0] sum,
    output logic [atcc_pkg::AVG_W-1:0] avg
);
    import atcc_pkg::*;

    // shift of sum width plus log2 of divisor makes the rounded-up
    // reciprocal exact for every sum below 2**SUM_W
    localparam int SHIFT  = SUM_W + $clog2(SAMPLES_PER_AVERAGE);
    localparam int MAGIC  = ((2 ** SHIFT) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE;
    localparam int PROD_W = SUM_W + SHIFT + 1;

    logic [PROD_W-1:0] prod;

    assign prod = PROD_W'(sum) * PROD_W'(MAGIC);
    assign avg  = prod[SHIFT +: AVG_W];

endmodule

// ===== design/averaged_telemetry_charge_control.sv =====
// top level: sample accumulation, group output buffer and charge hysteresis
// depends on atcc_pkg and atcc_avg_div
`timescale 1ns / 1ps

// Samples arrive in channel order: SAMPLES_PER_AVERAGE for temperature, then
// as many for voltage, then for current, repeating. One sample is accepted
// per cycle, but for the wait below; a sample that does not finish a group
// produces nothing. The sample that finishes a group loads a one-group
// output buffer, which then sends three bytes (two tag letters and the
// truncated average), one per cycle while m_ready is high. Accumulation
// goes on while the buffer drains; only a group-finishing sample waits,
// and only while the buffer still holds bytes other than the one leaving
// this cycle. After rounds_per_decision complete rounds (0 acts as 1) the
// last voltage average is compared with the thresholds when the current
// group finishes, and the three bytes of that group already show the new
// charge level. Registers are written through cfg_wr_en / cfg_index /
// cfg_wdata, taken at once; indexes beyond the list are ignored. Write
// them only while idle.
module averaged_telemetry_charge_control #(
    parameter int SAMPLES_PER_AVERAGE = atcc_pkg::SAMPLES_PER_AVERAGE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration writes
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_index,
    input  logic [atcc_pkg::CFG_W-1:0]    cfg_wdata,
    // sample requests
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [atcc_pkg::SAMPLE_W-1:0] s_sample,
    // telemetry requests
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [atcc_pkg::BYTE_W-1:0]   m_tx_byte,
    output logic [atcc_pkg::CH_W-1:0]     m_group_channel,
    output logic                          m_last_byte,
    output logic                          m_charge_on
);
    import atcc_pkg::*;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_AVERAGE - 1);

    // configuration registers
    logic [7:0]         high_thr_reg;
    logic [7:0]         low_thr_reg;
    logic [ROUND_W-1:0] rounds_reg;

    // accumulation state
    logic [SUM_W-1:0]   sum_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CH_W-1:0]    chan_reg;
    logic [ROUND_W-1:0] round_reg;
    logic [AVG_W-1:0]   last_volt_reg;
    logic               charge_reg;

    // output buffer, one group
    logic               grp_valid_reg;
    logic [IDX_W-1:0]   pos_reg;
    logic [AVG_W-1:0]   grp_avg_reg;
    logic [CH_W-1:0]    grp_ch_reg;

    logic [SUM_W-1:0]   sum_upd;
    logic [AVG_W-1:0]   avg;
    logic               cnt_last;
    logic               buf_free;
    logic               s_fire;
    logic               m_fire;
    logic               grp_done;
    logic [ROUND_W-1:0] round_need;
    logic [ROUND_W-1:0] round_inc;
    logic               decide;

    assign sum_upd  = sum_reg + SUM_W'(s_sample);
    assign cnt_last = (count_reg == CNT_LAST);
    assign m_fire   = grp_valid_reg && m_ready;
    // buffer can take a new group if empty or its final byte leaves now
    assign buf_free = !grp_valid_reg || (m_ready && pos_reg == POS_AVG);
    assign s_ready  = !cnt_last || buf_free;
    assign s_fire   = s_valid && s_ready;
    assign grp_done = s_fire && cnt_last;

    atcc_avg_div #(
        .SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE)
    ) u_div (
        .sum(sum_upd),
        .avg(avg)
    );

    // round counting, zero rounds acts as one, a counter wrap also decides
    assign round_need = (rounds_reg == '0) ? ROUND_W'(1) : rounds_reg;
    assign round_inc  = round_reg + ROUND_W'(1);
    assign decide     = (round_inc >= round_need) || (round_inc == '0);

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_thr_reg <= HIGH_THRESHOLD_RST;
            low_thr_reg  <= LOW_THRESHOLD_RST;
            rounds_reg   <= ROUNDS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_HIGH_THRESHOLD: high_thr_reg <= cfg_wdata;
                REG_LOW_THRESHOLD:  low_thr_reg  <= cfg_wdata;
                REG_ROUNDS:         rounds_reg   <= cfg_wdata[ROUND_W-1:0];
                default:            ;
            endcase
        end
    end

    // accumulation, channel sequencing and hysteresis
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            count_reg     <= '0;
            chan_reg      <= CH_TEMP;
            round_reg     <= '0;
            last_volt_reg <= '0;
            charge_reg    <= 1'b0;
        end else if (s_fire) begin
            if (!cnt_last) begin
                sum_reg   <= sum_upd;
                count_reg <= count_reg + CNT_W'(1);
            end else begin
                sum_reg   <= '0;
                count_reg <= '0;
                if (chan_reg == CH_VOLTAGE) begin
                    last_volt_reg <= avg;
                end
                if (chan_reg >= CH_CURRENT) begin
                    chan_reg <= CH_TEMP;
                    if (decide) begin
                        round_reg <= '0;
                        // on test first, so it wins if thresholds cross
                        if (last_volt_reg > high_thr_reg) begin
                            charge_reg <= 1'b1;
                        end else if (last_volt_reg < low_thr_reg) begin
                            charge_reg <= 1'b0;
                        end
                    end else begin
                        round_reg <= round_inc;
                    end
                end else begin
                    chan_reg <= chan_reg + CH_W'(1);
                end
            end
        end
    end

    // output buffer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_valid_reg <= 1'b0;
            pos_reg       <= POS_TAG0;
        end else if (grp_done) begin
            grp_valid_reg <= 1'b1;
            pos_reg       <= POS_TAG0;
        end else if (m_fire) begin
            if (pos_reg == POS_AVG) begin
                grp_valid_reg <= 1'b0;
                pos_reg       <= POS_TAG0;
            end else begin
                pos_reg <= pos_reg + IDX_W'(1);
            end
        end
    end

    // output buffer payload
    always_ff @(posedge aclk) begin
        if (grp_done) begin
            grp_avg_reg <= avg;
            grp_ch_reg  <= chan_reg;
        end
    end

    // byte selection
    always_comb begin
        case (pos_reg)
            POS_TAG0: m_tx_byte = tag_char(grp_ch_reg, 1'b0);
            POS_TAG1: m_tx_byte = tag_char(grp_ch_reg, 1'b1);
            default:  m_tx_byte = grp_avg_reg;
        endcase
    end

    assign m_valid         = grp_valid_reg;
    assign m_group_channel = grp_ch_reg;
    assign m_last_byte     = (pos_reg == POS_AVG);
    // the level only moves when a group loads, after the old group has left
    assign m_charge_on     = charge_reg;

    // a finished group always starts at its first tag letter
    a_load_first: assert property (@(posedge aclk) disable iff (!aresetn)
        grp_done |=> (grp_valid_reg && pos_reg == POS_TAG0))
        else $error("group load did not start at the first byte");

    // a finishing sample never overwrites bytes still waiting
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (grp_valid_reg && !(m_ready && pos_reg == POS_AVG)) |-> !grp_done)
        else $error("group buffer overrun");

    // charge level changes only when a current group finishes
    a_charge_src: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(charge_reg) |-> $past(grp_done && chan_reg >= CH_CURRENT))
        else $error("charge level changed outside a deciding group");

    // sample counter stays inside one group
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_LAST)
        else $error("sample counter out of range");

endmodule

// ===== tb/tb_averaged_telemetry_charge_control.sv =====
// self-checking testbench for averaged_telemetry_charge_control: directed and random sample traffic
// predicts every telemetry byte in-line and scoreboards results; depends on atcc_pkg and the design
`timescale 1ns / 1ps

module tb_averaged_telemetry_charge_control;
    import atcc_pkg::*;

    localparam int GROUP_LEN     = SAMPLES_PER_AVERAGE_DEF;
    localparam int SETTLE_CYCLES = 8;      // extra cycles after the last byte, before a write
    localparam int RANDOM_ITEMS  = 20;
    localparam logic [1:0] REG_SPARE = 2'd3;   // index with no register behind it

    typedef struct packed {
        logic [BYTE_W-1:0] tx_byte;
        logic [CH_W-1:0]   channel;
        logic              last_byte;
        logic              charge_on;
    } telemetry_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [1:0]          cfg_index;
    logic [CFG_W-1:0]    cfg_wdata;
    logic                s_valid;
    logic                s_ready;
    logic [SAMPLE_W-1:0] s_sample;
    logic                m_valid;
    logic                m_ready;
    logic [BYTE_W-1:0]   m_tx_byte;
    logic [CH_W-1:0]     m_group_channel;
    logic                m_last_byte;
    logic                m_charge_on;

    // predicted design state
    logic [SUM_W-1:0]    acc_sum;
    logic [CNT_W-1:0]    acc_count;
    logic [CH_W-1:0]     cur_channel;
    logic [ROUND_W-1:0]  rounds_done;
    logic [AVG_W-1:0]    volt_avg;
    logic                charge_lvl;
    // predicted register contents
    logic [7:0]          thr_high;
    logic [7:0]          thr_low;
    logic [ROUND_W-1:0]  rounds_cfg;

    telemetry_t telemetry_q[$];     // bytes still owed by the design, oldest first
    int         mismatch_count = 0;
    bit         tx_no_idle = 1'b0;  // sender runs back to back
    bit         rx_no_idle = 1'b0;  // receiver never stalls

    averaged_telemetry_charge_control dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample        (s_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_tx_byte       (m_tx_byte),
        .m_group_channel (m_group_channel),
        .m_last_byte     (m_last_byte),
        .m_charge_on     (m_charge_on)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // prediction: accumulate one sample, queue three bytes on group end
    // ------------------------------------------------------------------
    function automatic void accumulate_sample(input logic [SAMPLE_W-1:0] s);
        logic [AVG_W-1:0]   avg;
        logic [BYTE_W-1:0]  tag0;
        logic [BYTE_W-1:0]  tag1;
        logic [ROUND_W-1:0] need;
        logic [CH_W-1:0]    ch;
        ch      = cur_channel;
        acc_sum = acc_sum + SUM_W'(s);
        // group still filling: nothing to send
        if (int'(acc_count) + 1 < GROUP_LEN) begin
            acc_count = acc_count + CNT_W'(1);
            return;
        end
        avg       = AVG_W'(acc_sum / GROUP_LEN);
        acc_sum   = '0;
        acc_count = '0;
        case (ch)
            CH_TEMP: begin
                tag0 = CHR_P;
                tag1 = CHR_M;
            end
            CH_VOLTAGE: begin
                tag0     = CHR_S;
                tag1     = CHR_K;
                volt_avg = avg;
            end
            default: begin
                tag0 = CHR_F;
                tag1 = CHR_H;
            end
        endcase
        if (ch >= CH_CURRENT) begin
            // round complete; zero rounds behaves as one, counter wrap also decides
            need        = (rounds_cfg == '0) ? ROUND_W'(1) : rounds_cfg;
            rounds_done = rounds_done + ROUND_W'(1);
            if (rounds_done >= need || rounds_done == '0) begin
                rounds_done = '0;
                // on test first, so crossed thresholds favor charging
                if (volt_avg > thr_high)
                    charge_lvl = 1'b1;
                else if (volt_avg < thr_low)
                    charge_lvl = 1'b0;
            end
            cur_channel = CH_TEMP;
        end else begin
            cur_channel = ch + CH_W'(1);
        end
        telemetry_q.push_back('{tag0, ch, 1'b0, charge_lvl});
        telemetry_q.push_back('{tag1, ch, 1'b0, charge_lvl});
        telemetry_q.push_back('{avg, ch, 1'b1, charge_lvl});
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // shared drivers
    // ------------------------------------------------------------------
    // one sample request: random gap, then hold valid until accepted
    task automatic push_sample(input logic [SAMPLE_W-1:0] v);
        int gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= v;
        do @(posedge aclk); while (!s_ready);
        accumulate_sample(v);
    endtask

    // stop sending, let every owed byte arrive, then give the design time to settle
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (telemetry_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // register write, only called while the design is idle
    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_HIGH_THRESHOLD: thr_high   = val;
            REG_LOW_THRESHOLD:  thr_low    = val;
            REG_ROUNDS:         rounds_cfg = val[ROUND_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_level_group(input logic [SAMPLE_W-1:0] level);
        repeat (GROUP_LEN) push_sample(level);
    endtask

    task automatic send_noise_group();
        repeat (GROUP_LEN) push_sample(8'($urandom_range(0, 255)));
    endtask

    // one full round, each channel at a constant level so the average is exact
    task automatic send_round(input logic [7:0] temp, input logic [7:0] volt,
                              input logic [7:0] curr);
        send_level_group(temp);
        send_level_group(volt);
        send_level_group(curr);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // reset values: alternating-bit and full-scale groups; the voltage is
    // above the default on-threshold but one round of five does not decide
    task automatic test_default_rounds();
        for (int i = 0; i < GROUP_LEN; i++)
            push_sample((i % 2) ? 8'hAA : 8'h55);
        send_level_group(8'd240);
        send_level_group(8'hFF);
        wait_drained();
    endtask

    // high below low, and a rounds value of zero (upper data bits set) written
    // after one round is already done, so the next round decides
    task automatic test_crossed_thresholds();
        write_reg(REG_HIGH_THRESHOLD, 8'd0);
        write_reg(REG_LOW_THRESHOLD, 8'd255);
        write_reg(REG_ROUNDS, 8'hF0);
        send_round(8'd0, 8'd100, 8'd254);   // above high and below low: charging wins
        wait_drained();
    endtask

    // a write to the unused index must not land on any register
    task automatic test_spare_index();
        write_reg(REG_HIGH_THRESHOLD, 8'd200);
        write_reg(REG_LOW_THRESHOLD, 8'd100);
        write_reg(REG_ROUNDS, 8'h01);
        // a misdecoded write would zero a threshold and keep charging on
        write_reg(REG_SPARE, 8'h00);
        tx_no_idle = 1'b1;
        rx_no_idle = 1'b1;
        send_noise_group();
        send_level_group(8'd99);            // just below low: off
        send_noise_group();
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
        wait_drained();
    endtask

    // random samples with varied idle patterns, leaving a group open
    task automatic test_random_traffic();
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            tx_no_idle = ($urandom_range(0, 3) == 0);
            rx_no_idle = ($urandom_range(0, 3) == 0);
            push_sample(8'($urandom_range(0, 255)));
        end
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // result checker: random stalls on m_ready, compare with oldest byte
    // ------------------------------------------------------------------
    initial begin : telemetry_checker
        telemetry_t want;
        int         stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = rx_no_idle ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (telemetry_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected byte, expected none, actual %0d", $time, m_tx_byte);
            end else begin
                want = telemetry_q.pop_front();
                check_field("tx_byte", want.tx_byte, m_tx_byte);
                check_field("group_channel", 8'(want.channel), 8'(m_group_channel));
                check_field("last_byte", 8'(want.last_byte), 8'(m_last_byte));
                check_field("charge_on", 8'(want.charge_on), 8'(m_charge_on));
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        s_sample  <= '0;
        m_ready   <= 1'b0;
        // predictor starts from the reset state
        acc_sum     = '0;
        acc_count   = '0;
        cur_channel = CH_TEMP;
        rounds_done = '0;
        volt_avg    = '0;
        charge_lvl  = 1'b0;
        thr_high    = HIGH_THRESHOLD_RST;
        thr_low     = LOW_THRESHOLD_RST;
        rounds_cfg  = ROUNDS_RST;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_rounds();
        test_crossed_thresholds();
        test_spare_index();
        test_random_traffic();

        // everything owed has come; the settle window also catches stray bytes
        wait_drained();
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
